>>> hw/rtl/qfts_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the two-stack queue
package qfts_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 128;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_PEEK   = 2'd2,
      MODE_STATUS = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MOVE  = 4'b0010,
      ST_RDOUT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

>>> hw/rtl/qfts_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module qfts_ram #(
   parameter int WIDTH = qfts_pkg::DATA_W,
   parameter int DEPTH = qfts_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/queue_from_two_stacks.sv
`timescale 1ns / 1ps
// two-stack fifo queue top level: sequencer, counters and result register
// usage
//  - request channel: req_valid/req_stall with req_mode (push, pop, peek,
//    status) and req_value; one transaction is taken whenever the block is idle
//  - response channel: rsp_valid/rsp_stall, exactly one response transaction
//    per request, in request order
//  - push and status: the request is taken into the done state, from which
//    the result is loaded into the response register once it is free; the
//    next request is taken after that
//  - pop/peek with entries on the output stack: an extra read-out state for
//    the registered ram read before the done state
//  - pop/peek on an empty output stack walks the input stack one entry per
//    cycle through the ram ports in the move state, then goes to done
//  - reset clears both stack counts and the sequencer; ram contents are not
//    cleared since only entries below a count are ever used
//  - a stalled response holds in its register while the next request is
//    processed; that request then waits in the done state until the
//    response register frees up
module queue_from_two_stacks #(
   parameter int DEPTH = qfts_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic signed [qfts_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qfts_pkg::DATA_W-1:0] rsp_data,
   output logic                               rsp_empty_res,
   output logic                               rsp_underflow,
   output logic                               rsp_overflow
);
   import qfts_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer and stack pointers
   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [CW-1:0]     in_cnt_ff, in_cnt_in;
   logic [CW-1:0]     out_cnt_ff, out_cnt_in;
   logic [CW-1:0]     in_cnt_m1, in_cnt_m2, out_cnt_m1;

   // pending result of the transaction in flight
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   logic              res_under_ff, res_under_in;
   logic              res_over_ff, res_over_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_under_ff, rsp_under_in;
   logic              rsp_over_ff, rsp_over_in;

   // ram ports
   logic              in_wr_en, out_wr_en;
   logic [AW-1:0]     in_rd_addr;
   logic [DATA_W-1:0] in_rd_data, out_rd_data;

   logic              req_take;
   logic              rsp_free;

   assign in_cnt_m1  = in_cnt_ff - CW'(1);
   assign in_cnt_m2  = in_cnt_ff - CW'(2);
   assign out_cnt_m1 = out_cnt_ff - CW'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // during a refill the next read runs one entry ahead of the write
   assign in_rd_addr = (state_ff == ST_MOVE) ? in_cnt_m2[AW-1:0] : in_cnt_m1[AW-1:0];

   qfts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_in_ram (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_cnt_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   qfts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_cnt_ff[AW-1:0]),
      .wr_data (in_rd_data),
      .rd_addr (out_cnt_m1[AW-1:0]),
      .rd_data (out_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      res_data_in  = res_data_ff;
      res_under_in = res_under_ff;
      res_over_in  = res_over_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_under_in = rsp_under_ff;
      rsp_over_in  = rsp_over_ff;
      in_wr_en     = 1'b0;
      out_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in      = mode_type'(req_mode);
               res_data_in  = '0;
               res_under_in = 1'b0;
               res_over_in  = 1'b0;
               state_in     = ST_DONE;
               case (mode_type'(req_mode)) inside
                  MODE_PUSH: begin
                     if (in_cnt_ff == CW'(DEPTH)) begin
                        res_over_in = 1'b1;
                     end else begin
                        in_wr_en  = 1'b1;
                        in_cnt_in = in_cnt_ff + CW'(1);
                     end
                  end
                  MODE_POP, MODE_PEEK: begin
                     if (out_cnt_ff != '0) begin
                        state_in = ST_RDOUT;
                     end else if (in_cnt_ff != '0) begin
                        // refill: top of input stack already being read
                        state_in = ST_MOVE;
                     end else begin
                        res_under_in = 1'b1;
                        res_data_in  = (mode_type'(req_mode) == MODE_POP) ? '1 : '0;
                     end
                  end
                  default: begin
                     // status query leaves the stacks alone
                  end
               endcase
            end
         end
         ST_MOVE: begin
            out_wr_en = 1'b1;
            in_cnt_in = in_cnt_m1;
            if (in_cnt_m1 != '0) begin
               out_cnt_in = out_cnt_ff + CW'(1);
            end else begin
               // last entry moved is the oldest, take it straight from the read
               res_data_in = in_rd_data;
               out_cnt_in  = (mode_ff == MODE_POP) ? out_cnt_ff : out_cnt_ff + CW'(1);
               state_in    = ST_DONE;
            end
         end
         ST_RDOUT: begin
            res_data_in = out_rd_data;
            if (mode_ff == MODE_POP) begin
               out_cnt_in = out_cnt_m1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_empty_in = (in_cnt_ff == '0) && (out_cnt_ff == '0);
               rsp_under_in = res_under_ff;
               rsp_over_in  = res_over_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      res_data_ff  <= res_data_in;
      res_under_ff <= res_under_in;
      res_over_ff  <= res_over_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_under_ff <= rsp_under_in;
      rsp_over_ff  <= rsp_over_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_underflow = rsp_under_ff;
   assign rsp_overflow  = rsp_over_ff;
endmodule

>>> tb/sv/queue_from_two_stacks_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the two-stack queue: directed table, shaped random traffic
module queue_from_two_stacks_tb;
   import qfts_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int AW = $clog2(DEPTH);
   // a refill walks the whole input stack, so let that much time pass at the end
   localparam int SETTLE_CYCLES = DEPTH + 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 240;
   localparam int MAX_PRINTED = 40;

   localparam logic [31:0] MAX_POS  = 32'h7fff_ffff;
   localparam logic [31:0] MIN_NEG  = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     empty_res;
      logic                     underflow;
      logic                     overflow;
   } queue_result_type;

   localparam queue_result_type NO_RESULT = '0;

   // one line of the directed table; reps repeats the line, rand_value draws
   // a fresh value per repeat, fixed means the expected result is typed in
   typedef struct {
      mode_type         op;
      logic [31:0]      value;
      int               reps;
      bit               rand_value;
      bit               fixed;
      queue_result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_STATUS;
   logic signed [DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_data;
   logic rsp_empty_res;
   logic rsp_underflow;
   logic rsp_overflow;

   // typed expectation travels with the payload, driven the same way
   bit               row_fixed = 1'b0;
   queue_result_type row_want = '0;

   // predictor state: the two stacks and their fill levels
   logic [31:0] in_stack [DEPTH];
   logic [31:0] out_stack [DEPTH];
   int in_depth = 0;
   int out_depth = 0;

   queue_result_type awaited_results [$];
   plan_row_type plan [$];

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int underflows_seen = 0;
   int overflows_seen = 0;
   int refills_seen = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   queue_from_two_stacks #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .rsp_empty_res (rsp_empty_res),
      .rsp_underflow (rsp_underflow),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycles, awaited_results.size());
         $display("queue_from_two_stacks_tb: errors");
         $finish;
      end
   end

   // receiver side: random stall per cycle at the phase's rate
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // expected result of one transaction; updates the predicted stacks
   function automatic queue_result_type queue_op_outcome(input mode_type op,
                                                         input logic [31:0] value);
      queue_result_type res;
      res = '0;
      case (op) inside
         MODE_PUSH: begin
            // a full input stack drops the push even if the output side has room
            if (in_depth >= DEPTH) begin
               res.overflow = 1'b1;
            end else begin
               in_stack[AW'(in_depth)] = value;
               in_depth++;
            end
         end
         MODE_POP, MODE_PEEK: begin
            // refill only from an empty output stack; order reverses on the move
            if (out_depth == 0 && in_depth != 0) begin
               refills_seen++;
               while (in_depth != 0) begin
                  in_depth--;
                  out_stack[AW'(out_depth)] = in_stack[AW'(in_depth)];
                  out_depth++;
               end
            end
            if (out_depth == 0) begin
               res.underflow = 1'b1;
               res.data = (op == MODE_POP) ? ALL_ONES : '0;
            end else begin
               res.data = out_stack[AW'(out_depth - 1)];
               if (op == MODE_POP)
                  out_depth--;
            end
         end
         default: ;
      endcase
      res.empty_res = (in_depth == 0 && out_depth == 0);
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("mismatch at %0t, result %0d: %0s got %h want %h",
                  $realtime, results_checked, what, got, want);
   endtask

   // transaction monitor: predict on request acceptance, check on response acceptance
   always @(posedge clock) begin : watch
      queue_result_type want;
      queue_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = queue_op_outcome(mode_type'(req_mode), req_value);
            if (row_fixed)
               want = row_want;
            awaited_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_data, rsp_empty_res, rsp_underflow, rsp_overflow};
            if (awaited_results.size() == 0) begin
               flag_mismatch("response with nothing awaited", got.data, '0);
            end else begin
               want = awaited_results.pop_front();
               if (got.data !== want.data)
                  flag_mismatch("data", got.data, want.data);
               if (got.empty_res !== want.empty_res)
                  flag_mismatch("empty_res", 32'(got.empty_res), 32'(want.empty_res));
               if (got.underflow !== want.underflow)
                  flag_mismatch("underflow", 32'(got.underflow), 32'(want.underflow));
               if (got.overflow !== want.overflow)
                  flag_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
               if (got.underflow === 1'b1)
                  underflows_seen++;
               if (got.overflow === 1'b1)
                  overflows_seen++;
            end
            results_checked++;
         end
      end
   end

   // present one transaction and hold it until taken; valid stays high after
   // acceptance so a back-to-back transaction never toggles it in one step
   task automatic send_item(input mode_type op, input logic [31:0] value,
                            input bit fixed, input queue_result_type want);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= op;
      req_value <= value;
      row_fixed <= fixed;
      row_want  <= want;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic add_row(input mode_type op, input logic [31:0] value, input int reps,
                          input bit rand_value, input bit fixed,
                          input queue_result_type want);
      plan_row_type row;
      row = '{op, value, reps, rand_value, fixed, want};
      plan.push_back(row);
   endtask

   // random words half the time, the sign and range extremes the other half
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return MAX_POS;
         1: return MIN_NEG;
         2: return '0;
         3: return ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   function automatic mode_type pick_take();
      return ($urandom_range(0, 3) == 0) ? MODE_PEEK : MODE_POP;
   endfunction

   // shaped random traffic: push bursts followed by take bursts dominate, with
   // drains past empty, fills past full and plain noise mixed in
   task automatic run_random(input int count);
      int stop_at;
      int burst;
      int guard;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_item(MODE_PUSH, pick_value(), 1'b0, NO_RESULT);
            burst = $urandom_range(1, 12);
            repeat (burst) send_item(pick_take(), pick_value(), 1'b0, NO_RESULT);
         end else if (pick < 70) begin
            send_item(mode_type'($urandom_range(0, 3)), $urandom, 1'b0, NO_RESULT);
         end else if (pick < 86) begin
            // drain to empty, then a take or two into underflow
            guard = 0;
            while (in_depth + out_depth > 0 && guard < 2 * DEPTH + 4) begin
               send_item(pick_take(), pick_value(), 1'b0, NO_RESULT);
               guard++;
            end
            burst = $urandom_range(1, 2);
            repeat (burst) send_item(pick_take(), pick_value(), 1'b0, NO_RESULT);
         end else if (pick < 90) begin
            // fill the input stack, then push into overflow
            guard = 0;
            while (in_depth < DEPTH && guard < DEPTH + 4) begin
               send_item(MODE_PUSH, $urandom, 1'b0, NO_RESULT);
               guard++;
            end
            burst = $urandom_range(1, 3);
            repeat (burst) send_item(MODE_PUSH, pick_value(), 1'b0, NO_RESULT);
         end else begin
            burst = $urandom_range(1, 8);
            repeat (burst)
               send_item(mode_type'($urandom_range(0, 3)), $urandom, 1'b0, NO_RESULT);
         end
      end
   endtask

   initial begin : stimulus
      int settle;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table: empty queue, sign extremes, ordering across a refill,
      // pushes landing in the input stack while the output stack is busy,
      // overflow with an empty output stack, drain to empty
      add_row(MODE_STATUS, '0, 1, 0, 1, queue_result_type'{32'h0, 1'b1, 1'b0, 1'b0});
      add_row(MODE_POP, '0, 1, 0, 1, queue_result_type'{ALL_ONES, 1'b1, 1'b1, 1'b0});
      add_row(MODE_PEEK, '0, 1, 0, 1, queue_result_type'{32'h0, 1'b1, 1'b1, 1'b0});
      add_row(MODE_PUSH, MAX_POS, 1, 0, 1, queue_result_type'{32'h0, 1'b0, 1'b0, 1'b0});
      add_row(MODE_PUSH, MIN_NEG, 1, 0, 1, queue_result_type'{32'h0, 1'b0, 1'b0, 1'b0});
      add_row(MODE_PUSH, '0, 1, 0, 0, NO_RESULT);
      add_row(MODE_PUSH, ALL_ONES, 1, 0, 0, NO_RESULT);
      add_row(MODE_STATUS, ALL_ONES, 1, 0, 1, queue_result_type'{32'h0, 1'b0, 1'b0, 1'b0});
      add_row(MODE_PEEK, '0, 1, 0, 1, queue_result_type'{MAX_POS, 1'b0, 1'b0, 1'b0});
      add_row(MODE_POP, '0, 1, 0, 1, queue_result_type'{MAX_POS, 1'b0, 1'b0, 1'b0});
      add_row(MODE_PUSH, 32'h1, 1, 0, 0, NO_RESULT);
      add_row(MODE_POP, '0, 1, 0, 1, queue_result_type'{MIN_NEG, 1'b0, 1'b0, 1'b0});
      add_row(MODE_POP, '0, 1, 0, 0, NO_RESULT);
      add_row(MODE_POP, '0, 1, 0, 1, queue_result_type'{ALL_ONES, 1'b0, 1'b0, 1'b0});
      add_row(MODE_PEEK, '0, 1, 0, 0, NO_RESULT);
      add_row(MODE_POP, '0, 1, 0, 1, queue_result_type'{32'h1, 1'b1, 1'b0, 1'b0});
      add_row(MODE_PEEK, '0, 1, 0, 1, queue_result_type'{32'h0, 1'b1, 1'b1, 1'b0});
      add_row(MODE_PUSH, '0, DEPTH, 1, 0, NO_RESULT);
      add_row(MODE_PUSH, MAX_POS, 1, 0, 1, queue_result_type'{32'h0, 1'b0, 1'b0, 1'b1});
      add_row(MODE_PEEK, '0, 1, 0, 0, NO_RESULT);
      add_row(MODE_STATUS, '0, 1, 0, 1, queue_result_type'{32'h0, 1'b0, 1'b0, 1'b0});
      add_row(MODE_POP, '0, DEPTH, 0, 0, NO_RESULT);
      add_row(MODE_POP, '0, 1, 0, 1, queue_result_type'{ALL_ONES, 1'b1, 1'b1, 1'b0});
      add_row(MODE_STATUS, '0, 1, 0, 1, queue_result_type'{32'h0, 1'b1, 1'b0, 1'b0});

      foreach (plan[i])
         repeat (plan[i].reps)
            send_item(plan[i].op, plan[i].rand_value ? $urandom : plan[i].value,
                      plan[i].fixed, plan[i].want);

      // random traffic under four idling patterns
      send_idle_pct = 0;
      stall_pct = 0;
      run_random(RANDOM_ITEMS / 4);
      send_idle_pct = 77;
      stall_pct = 0;
      run_random(RANDOM_ITEMS / 4);
      send_idle_pct = 0;
      stall_pct = 77;
      run_random(RANDOM_ITEMS / 4);
      send_idle_pct = 27;
      stall_pct = 27;
      run_random(RANDOM_ITEMS / 4);

      // all requests taken: drop valid, drain responses, then watch for strays
      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      for (settle = 0; settle < SETTLE_CYCLES; settle++)
         @(posedge clock);

      $display("covered %0d transactions, %0d results checked, %0d refills",
               items_sent, results_checked, refills_seen);
      $display("flags seen: %0d underflows, %0d overflows; %0d mismatches",
               underflows_seen, overflows_seen, errors);
      if (errors == 0)
         $display("queue_from_two_stacks_tb: clean");
      else
         $display("queue_from_two_stacks_tb: errors");
      $finish;
   end

endmodule
